@@ rtl/pmm_pkg.sv @@
// Package for the P-256 Montgomery multiplier: word types, limb types and the prime.
// Also holds the split-multiply helpers that the round stages use.
// Depends on nothing.
package pmm_pkg;

    localparam int LIMB_BITS = 52;
    localparam int NUM_LIMBS = 5;
    localparam int HALF_BITS = LIMB_BITS / 2;
    localparam int ACC_BITS  = 64;
    localparam int PROD_BITS = 2 * LIMB_BITS;

    typedef struct packed {
        logic [LIMB_BITS-1:0] a_limb0;
        logic [LIMB_BITS-1:0] a_limb1;
        logic [LIMB_BITS-1:0] a_limb2;
        logic [LIMB_BITS-1:0] a_limb3;
        logic [LIMB_BITS-1:0] a_limb4;
        logic [LIMB_BITS-1:0] b_limb0;
        logic [LIMB_BITS-1:0] b_limb1;
        logic [LIMB_BITS-1:0] b_limb2;
        logic [LIMB_BITS-1:0] b_limb3;
        logic [LIMB_BITS-1:0] b_limb4;
    } t_in_word;

    typedef struct packed {
        logic [LIMB_BITS-1:0] r_limb0;
        logic [LIMB_BITS-1:0] r_limb1;
        logic [LIMB_BITS-1:0] r_limb2;
        logic [LIMB_BITS-1:0] r_limb3;
        logic [LIMB_BITS-1:0] r_limb4;
    } t_out_word;

    typedef logic [NUM_LIMBS-1:0][LIMB_BITS-1:0] t_limbs;
    typedef logic [NUM_LIMBS-1:0][ACC_BITS-1:0]  t_accs;
    // Four 26x26 partial products of one 52x52 multiply.
    typedef logic [3:0][LIMB_BITS-1:0]           t_pp;
    typedef logic [NUM_LIMBS-1:0][3:0][LIMB_BITS-1:0] t_pps;

    // Round entry: operands and accumulator.
    typedef struct packed {
        t_limbs a;
        t_limbs b;
        t_accs  acc;
    } t_sa;

    typedef struct packed {
        t_limbs a;
        t_limbs b;
        t_accs  acc;
        t_pps   pp;
    } t_sb;

    typedef struct packed {
        t_limbs               a;
        t_limbs               b;
        t_accs                lowp;
        t_accs                highp;
        logic [LIMB_BITS-1:0] q;
    } t_sc;

    typedef struct packed {
        t_limbs a;
        t_limbs b;
        t_accs  lowp;
        t_accs  highp;
        t_pps   pp;
    } t_sd;

    localparam t_limbs PRIME = {52'h0ffffffff0000, 52'h0001000000000, 52'h0,
                                52'h00fffffffffff, 52'hfffffffffffff};

    function automatic t_pp pp_split(input logic [LIMB_BITS-1:0] x,
                                     input logic [LIMB_BITS-1:0] y);
        logic [HALF_BITS-1:0] xl, xh, yl, yh;
        t_pp res;
        xl = x[HALF_BITS-1:0];
        xh = x[LIMB_BITS-1:HALF_BITS];
        yl = y[HALF_BITS-1:0];
        yh = y[LIMB_BITS-1:HALF_BITS];
        res[0] = LIMB_BITS'(xl) * LIMB_BITS'(yl);
        res[1] = LIMB_BITS'(xh) * LIMB_BITS'(yl);
        res[2] = LIMB_BITS'(xl) * LIMB_BITS'(yh);
        res[3] = LIMB_BITS'(xh) * LIMB_BITS'(yh);
        return res;
    endfunction

    function automatic logic [PROD_BITS-1:0] pp_join(input t_pp pp);
        return PROD_BITS'(pp[0])
             + (PROD_BITS'(pp[1]) << HALF_BITS)
             + (PROD_BITS'(pp[2]) << HALF_BITS)
             + (PROD_BITS'(pp[3]) << LIMB_BITS);
    endfunction

    // Arithmetic shift right by one limb of a 64-bit accumulator lane.
    function automatic logic [ACC_BITS-1:0] sign_shift(input logic [ACC_BITS-1:0] v);
        return {{LIMB_BITS{v[ACC_BITS-1]}}, v[ACC_BITS-1:LIMB_BITS]};
    endfunction

endpackage

@@ rtl/p256_montgomery_multiplier.sv @@
// Top level of the P-256 Montgomery multiplier, r = a*b*2^-260 mod p.
// Depends on pmm_pkg.
//
// The multiplier takes one word per cycle while o_stall is low. Each of the five Montgomery
// rounds takes four register stages (operand partial products, accumulate and quotient, prime
// partial products, accumulate and shift), followed by two stages of carry propagation and the
// final choice. A stall on the output freezes the whole pipeline, so the input is stalled only
// while a finished word waits at the output and nothing can move.
module p256_montgomery_multiplier (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  pmm_pkg::t_in_word i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output pmm_pkg::t_out_word o_data
);
    import pmm_pkg::*;

    localparam int NSTG = 4 * NUM_LIMBS + 3;

    logic              en;
    logic [NSTG-1:0]   r_vld;
    t_sa               r_sa [NUM_LIMBS+1];
    t_sb               r_sb [NUM_LIMBS];
    t_sc               r_sc [NUM_LIMBS];
    t_sd               r_sd [NUM_LIMBS];
    t_accs             r_f_acc, r_f_diff, n_f_acc, n_f_diff;
    t_out_word         r_out, n_out;
    t_sa               n_sa0;

    assign en      = !(r_vld[NSTG-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[NSTG-1];
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_comb begin
        n_sa0.a   = {i_data.a_limb4, i_data.a_limb3, i_data.a_limb2,
                     i_data.a_limb1, i_data.a_limb0};
        n_sa0.b   = {i_data.b_limb4, i_data.b_limb3, i_data.b_limb2,
                     i_data.b_limb1, i_data.b_limb0};
        n_sa0.acc = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sa[0] <= n_sa0;
        end
    end

    for (genvar r = 0; r < NUM_LIMBS; r++) begin : g_rnd
        t_sb n_sb;
        t_sc n_sc;
        t_sd n_sd;
        t_sa n_sa;

        always_comb begin
            n_sb.a   = r_sa[r].a;
            n_sb.b   = r_sa[r].b;
            n_sb.acc = r_sa[r].acc;
            for (int j = 0; j < NUM_LIMBS; j++) begin
                n_sb.pp[j] = pp_split(r_sa[r].a[j], r_sa[r].b[r]);
            end
        end

        always_comb begin : p_acc
            logic [PROD_BITS-1:0] prod;
            prod = '0;
            n_sc.a = r_sb[r].a;
            n_sc.b = r_sb[r].b;
            for (int j = 0; j < NUM_LIMBS; j++) begin
                prod          = pp_join(r_sb[r].pp[j]);
                n_sc.lowp[j]  = r_sb[r].acc[j] + ACC_BITS'(prod[LIMB_BITS-1:0]);
                n_sc.highp[j] = ACC_BITS'(prod[PROD_BITS-1:LIMB_BITS]);
            end
            // The prime is -1 mod 2^52, so the quotient digit is the low limb itself.
            n_sc.q = n_sc.lowp[0][LIMB_BITS-1:0];
        end

        always_comb begin
            n_sd.a     = r_sc[r].a;
            n_sd.b     = r_sc[r].b;
            n_sd.lowp  = r_sc[r].lowp;
            n_sd.highp = r_sc[r].highp;
            for (int j = 0; j < NUM_LIMBS; j++) begin
                n_sd.pp[j] = pp_split(PRIME[j], r_sc[r].q);
            end
        end

        always_comb begin : p_red
            logic [PROD_BITS-1:0] prod;
            t_accs                lp, hp;
            prod = '0;
            for (int j = 0; j < NUM_LIMBS; j++) begin
                prod  = pp_join(r_sd[r].pp[j]);
                lp[j] = r_sd[r].lowp[j] + ACC_BITS'(prod[LIMB_BITS-1:0]);
                hp[j] = r_sd[r].highp[j] + ACC_BITS'(prod[PROD_BITS-1:LIMB_BITS]);
            end
            hp[0] = hp[0] + ACC_BITS'(lp[0][ACC_BITS-1:LIMB_BITS]);
            n_sa.a = r_sd[r].a;
            n_sa.b = r_sd[r].b;
            for (int j = 0; j < NUM_LIMBS - 1; j++) begin
                n_sa.acc[j] = lp[j+1] + hp[j];
            end
            n_sa.acc[NUM_LIMBS-1] = hp[NUM_LIMBS-1];
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sb[r]   <= n_sb;
                r_sc[r]   <= n_sc;
                r_sd[r]   <= n_sd;
                r_sa[r+1] <= n_sa;
            end
        end
    end

    // First half of the carry propagation, for acc and for acc - p side by side.
    always_comb begin
        for (int j = 0; j < NUM_LIMBS; j++) begin
            n_f_acc[j]  = r_sa[NUM_LIMBS].acc[j];
            n_f_diff[j] = r_sa[NUM_LIMBS].acc[j] - ACC_BITS'(PRIME[j]);
        end
        for (int j = 1; j < 3; j++) begin
            n_f_acc[j]  = n_f_acc[j] + sign_shift(n_f_acc[j-1]);
            n_f_diff[j] = n_f_diff[j] + sign_shift(n_f_diff[j-1]);
        end
    end

    always_comb begin : p_fin
        t_accs va, vd;
        t_limbs res;
        va = r_f_acc;
        vd = r_f_diff;
        for (int j = 3; j < NUM_LIMBS; j++) begin
            va[j] = va[j] + sign_shift(va[j-1]);
            vd[j] = vd[j] + sign_shift(vd[j-1]);
        end
        // A negative top limb of the difference means the sum was already below p.
        for (int j = 0; j < NUM_LIMBS; j++) begin
            res[j] = vd[NUM_LIMBS-1][ACC_BITS-1] ? va[j][LIMB_BITS-1:0]
                                                 : vd[j][LIMB_BITS-1:0];
        end
        n_out.r_limb0 = res[0];
        n_out.r_limb1 = res[1];
        n_out.r_limb2 = res[2];
        n_out.r_limb3 = res[3];
        n_out.r_limb4 = res[4];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_acc  <= n_f_acc;
            r_f_diff <= n_f_diff;
            r_out    <= n_out;
        end
    end

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted word did not enter the pipeline");

    a_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_stall && r_vld[NSTG-2]) |=> o_valid)
        else $error("finished word lost before the output");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_stall && !i_valid && !r_vld[NSTG-1]) |=>
            $countones(r_vld) == $past($countones(r_vld)))
        else $error("word count in the pipeline changed without a handshake");

endmodule

@@ verif/p256_montgomery_multiplier_checker.sv @@
// Checker for the P-256 Montgomery multiplier: watches both channels, predicts each product
// with its own round-by-round model and compares limb by limb.
// Depends on pmm_pkg for the word types.
`timescale 1ns / 1ps
module p256_montgomery_multiplier_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  pmm_pkg::t_in_word  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  pmm_pkg::t_out_word i_out_data,
    output int                 o_fail_count,
    output int                 o_product_count
);
    import pmm_pkg::*;

    localparam logic [63:0] LMASK = 64'h000fffffffffffff;

    t_out_word expected_products[$];

    function automatic logic [63:0] prime_limb(input int k);
        case (k)
            0: prime_limb = 64'h000fffffffffffff;
            1: prime_limb = 64'h00000fffffffffff;
            2: prime_limb = 64'h0;
            3: prime_limb = 64'h0000001000000000;
            default: prime_limb = 64'h0000ffffffff0000;
        endcase
    endfunction

    function automatic logic [63:0] asr_limb(input logic [63:0] v);
        asr_limb = {{52{v[63]}}, v[63:52]};
    endfunction

    function automatic t_out_word mont_product(input t_in_word w);
        logic [63:0] a [5];
        logic [63:0] b [5];
        logic [63:0] acc [5];
        logic [63:0] lowp [5];
        logic [63:0] highp [5];
        logic [63:0] diff [5];
        logic [103:0] prod;
        logic [63:0] q;
        logic [63:0] sel [5];
        t_out_word r;
        a = '{64'(w.a_limb0), 64'(w.a_limb1), 64'(w.a_limb2), 64'(w.a_limb3),
              64'(w.a_limb4)};
        b = '{64'(w.b_limb0), 64'(w.b_limb1), 64'(w.b_limb2), 64'(w.b_limb3),
              64'(w.b_limb4)};
        for (int j = 0; j < 5; j++) acc[j] = '0;
        for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 5; j++) begin
                prod = 104'(a[j]) * 104'(b[i]);
                lowp[j] = acc[j] + (64'(prod) & LMASK);
                highp[j] = 64'(prod >> 52);
            end
            q = lowp[0] & LMASK;
            for (int j = 0; j < 5; j++) begin
                prod = 104'(prime_limb(j)) * 104'(q);
                lowp[j] += 64'(prod) & LMASK;
                highp[j] += 64'(prod >> 52);
            end
            highp[0] += lowp[0] >> 52;
            for (int j = 0; j < 5; j++)
                acc[j] = (j < 4 ? lowp[j + 1] : 64'd0) + highp[j];
        end
        for (int j = 0; j < 5; j++) diff[j] = acc[j] - prime_limb(j);
        for (int k = 1; k < 5; k++) begin
            diff[k] += asr_limb(diff[k - 1]);
            acc[k] += asr_limb(acc[k - 1]);
        end
        for (int j = 0; j < 5; j++) sel[j] = diff[4][63] ? acc[j] : diff[j];
        r.r_limb0 = sel[0][51:0];
        r.r_limb1 = sel[1][51:0];
        r.r_limb2 = sel[2][51:0];
        r.r_limb3 = sel[3][51:0];
        r.r_limb4 = sel[4][51:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [51:0] got,
                                   input logic [51:0] want);
        $display("MISMATCH product %0d %s: got %h expected %h",
                 o_product_count, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_product_count = 0;
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall)
                expected_products.push_back(mont_product(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (expected_products.size() == 0) begin
                    report_mismatch("r_limb0 of a word with no product pending",
                                    i_out_data.r_limb0, '0);
                end else begin
                    want = expected_products.pop_front();
                    if (i_out_data.r_limb0 !== want.r_limb0)
                        report_mismatch("r_limb0", i_out_data.r_limb0, want.r_limb0);
                    if (i_out_data.r_limb1 !== want.r_limb1)
                        report_mismatch("r_limb1", i_out_data.r_limb1, want.r_limb1);
                    if (i_out_data.r_limb2 !== want.r_limb2)
                        report_mismatch("r_limb2", i_out_data.r_limb2, want.r_limb2);
                    if (i_out_data.r_limb3 !== want.r_limb3)
                        report_mismatch("r_limb3", i_out_data.r_limb3, want.r_limb3);
                    if (i_out_data.r_limb4 !== want.r_limb4)
                        report_mismatch("r_limb4", i_out_data.r_limb4, want.r_limb4);
                end
                o_product_count++;
            end
        end
    end

    function automatic int pending_products();
        return expected_products.size();
    endfunction

endmodule

@@ verif/p256_montgomery_multiplier_tb.sv @@
// Testbench top for the P-256 Montgomery multiplier: drives operand words with random gaps
// and output stalls, and gives the verdict from the checker's failure count and pending products.
// Depends on pmm_pkg, the multiplier and p256_montgomery_multiplier_checker.
`timescale 1ns / 1ps
module p256_montgomery_multiplier_tb;
    import pmm_pkg::*;

    localparam int NUM_RANDOM  = 600;
    localparam int WATCH_LIMIT = 2000;
    localparam int LATENCY     = 23;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_data;
    int        fail_count;
    int        product_count;
    int        sent_count = 0;
    int        idle_cycles = 0;
    bit        quiet_phase = 1'b0;

    always #10 clk = ~clk;

    p256_montgomery_multiplier dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_data(in_data), .o_valid(out_valid), .i_stall(out_stall), .o_data(out_data)
    );

    p256_montgomery_multiplier_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_product_count(product_count)
    );

    function automatic logic [51:0] rand_limb();
        return {20'($urandom_range(20'hfffff, 0)), $urandom()};
    endfunction

    // Random limb that favors the edges of the range and the prime's own limbs.
    function automatic logic [51:0] pick_limb(input int k);
        logic [51:0] p;
        p = PRIME[k];
        case ($urandom_range(9, 0))
            0: return '0;
            1: return '1;
            2: return p;
            3: return p - 52'd1;
            4: return 52'd1;
            default: return rand_limb();
        endcase
    endfunction

    // Operand, usually below p: top limb kept below the prime's top limb most of the time.
    function automatic t_limbs pick_operand();
        t_limbs v;
        for (int k = 0; k < NUM_LIMBS; k++) v[k] = pick_limb(k);
        if ($urandom_range(9, 0) != 0 && v[4] >= PRIME[4])
            v[4] = v[4] % PRIME[4];
        return v;
    endfunction

    function automatic t_in_word make_word(input t_limbs a, input t_limbs b);
        t_in_word w;
        w.a_limb0 = a[0]; w.a_limb1 = a[1]; w.a_limb2 = a[2];
        w.a_limb3 = a[3]; w.a_limb4 = a[4];
        w.b_limb0 = b[0]; w.b_limb1 = b[1]; w.b_limb2 = b[2];
        w.b_limb3 = b[3]; w.b_limb4 = b[4];
        return w;
    endfunction

    // Presents one word and holds it until the multiplier takes it.
    task automatic send_word(input t_in_word w);
        int gap;
        if (!quiet_phase && $urandom_range(3, 0) == 0) begin
            gap = $urandom_range(19, 1);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        sent_count++;
    endtask

    // Output stall in bursts.
    initial begin
        @(posedge rst_n);
        while (1) begin
            @(negedge clk);
            if (!quiet_phase && $urandom_range(4, 0) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(19, 1)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && idle_cycles >= WATCH_LIMIT) begin
            $display("watchdog expired after %0d words", sent_count);
            $display("p256_montgomery_multiplier verification failed");
            $finish;
        end
    end

    initial begin
        t_limbs zero_v, one_v, max_v, pm1_v, mont_one;
        zero_v = '0;
        one_v = '0;
        one_v[0] = 52'd1;
        max_v = '1;
        pm1_v = PRIME;
        pm1_v[0] = PRIME[0] - 52'd1;
        // 2^260 mod p, the Montgomery form of one.
        mont_one = '0;
        mont_one[0] = 52'h0000000000010;
        mont_one[1] = 52'hf000000000000;
        mont_one[2] = 52'hfffffffffffff;
        mont_one[3] = 52'hffeffffffffff;
        mont_one[4] = 52'h00000000fffff;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // Directed words: zero, one, the Montgomery one, p-1, p itself and all-ones patterns.
        send_word(make_word(zero_v, zero_v));
        send_word(make_word(zero_v, pm1_v));
        send_word(make_word(one_v, one_v));
        send_word(make_word(mont_one, mont_one));
        send_word(make_word(mont_one, pm1_v));
        send_word(make_word(pm1_v, pm1_v));
        send_word(make_word(pm1_v, one_v));
        send_word(make_word(PRIME, pm1_v));
        send_word(make_word(PRIME, PRIME));
        send_word(make_word(max_v, max_v));
        send_word(make_word(max_v, one_v));
        send_word(make_word(zero_v, max_v));
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM - 100) quiet_phase = 1'b1;
            send_word(make_word(pick_operand(), pick_operand()));
        end
        in_valid <= 1'b0;
        while (product_count < sent_count) @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
        $display("Ran %0d products through the multiplier, 12 directed and %0d random,",
                 sent_count, NUM_RANDOM);
        $display("with bursty input gaps and output stalls before a gap-free tail.");
        if (fail_count == 0 && checker_i.pending_products() == 0)
            $display("p256_montgomery_multiplier verification clean");
        else
            $display("p256_montgomery_multiplier verification failed");
        $finish;
    end

endmodule

@@ p256_montgomery_multiplier.f @@
rtl/pmm_pkg.sv
rtl/p256_montgomery_multiplier.sv
verif/p256_montgomery_multiplier_checker.sv
verif/p256_montgomery_multiplier_tb.sv
